>>> src/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SOR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sor_pkg.sv
`timescale 1ns / 1ps
package sor_pkg;

  localparam int MaxUnknownsDef = 64;

  localparam logic [6:0]  SysSizeRst  = 7'd64;
  localparam logic [33:0] RelaxRst    = 34'h1_0000_0000;
  localparam logic [32:0] TolSqRst    = 33'd43;
  localparam logic [15:0] IterLimRst  = 16'hFFFF;

  localparam logic signed [63:0] QMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMin = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_SYSTEM_SIZE = 2'd0,
    REG_RELAX       = 2'd1,
    REG_TOL_SQ      = 2'd2,
    REG_ITER_LIMIT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [5:0]         row_index;
    logic [6:0]         col_index;
    logic signed [63:0] element_value;
    logic               load_done;
  } sor_in_t;

  typedef struct packed {
    logic [5:0]         unknown_index;
    logic signed [63:0] unknown_value;
    logic               last_unknown;
    logic               converged;
    logic               zero_pivot;
    logic [15:0]        sweeps_used;
  } sor_out_t;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DOT_RD  = 18'h00002,
    S_DOT_MUL = 18'h00004,
    S_DOT_WT  = 18'h00008,
    S_B_RD    = 18'h00010,
    S_B_USE   = 18'h00020,
    S_B_MUL   = 18'h00040,
    S_SQ_WT   = 18'h00080,
    S_WR_WT   = 18'h00100,
    S_PV_RD   = 18'h00200,
    S_DIV     = 18'h00400,
    S_DIV_WT  = 18'h00800,
    S_CMP     = 18'h01000,
    S_PIV_RD  = 18'h02000,
    S_PIV_CHK = 18'h04000,
    S_OUT_RD  = 18'h08000,
    S_OUT_LD  = 18'h10000,
    S_OUT_WT  = 18'h20000
  } sor_state_e;

  function automatic logic [63:0] q_mag(input logic signed [63:0] v);
    q_mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [63:0] q_from_mag(input logic neg, input logic [63:0] m);
    if (!neg) begin
      q_from_mag = m[63] ? QMax : $signed(m);
    end else begin
      q_from_mag = m[63] ? QMin : $signed(64'd0 - m);
    end
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      q_add = a[63] ? QMin : QMax;
    end else begin
      q_add = s;
    end
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      q_sub = a[63] ? QMin : QMax;
    end else begin
      q_sub = s;
    end
  endfunction

endpackage

>>> src/sor_ram.sv
`timescale 1ns / 1ps
module sor_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sor_mul.sv
`timescale 1ns / 1ps
module sor_mul import sor_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic         busy_q, busy_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         pvld_q, pvld_d;
  logic [63:0]  am_q, bm_q;
  logic         neg_q;
  logic [63:0]  prod_q;
  logic [1:0]   psh_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [127:0] addend;
  logic [63:0]  mag;

  always_comb begin
    ah = cnt_q[1] ? am_q[63:32] : am_q[31:0];
    bh = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
    unique case (psh_q)
      2'd0:    addend = {64'd0, prod_q};
      2'd1:    addend = {32'd0, prod_q, 32'd0};
      default: addend = {prod_q, 64'd0};
    endcase
    mag = (|acc_q[127:96]) ? '1 : acc_q[95:32];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    pvld_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
    end else if (busy_q) begin
      pvld_d = (cnt_q < 3'd4);
      cnt_d  = cnt_q + 3'd1;
      if (cnt_q == 3'd5) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      pvld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= q_mag(a_i);
      bm_q  <= q_mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= 64'(ah) * 64'(bh);
      psh_q  <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      if (pvld_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == 3'd5);
  assign res_o  = q_from_mag(neg_q, mag);

endmodule

>>> src/sor_div.sv
`timescale 1ns / 1ps
module sor_div import sor_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  localparam logic [6:0] Steps = 7'd96;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [95:0] dvd_q;
  logic [63:0] d_q, r_q, quo_q;
  logic        over_q, neg_q;
  logic [64:0] rn, diff;
  logic        ge;

  always_comb begin
    rn   = {r_q, dvd_q[95]};
    diff = rn - {1'b0, d_q};
    ge   = (rn >= {1'b0, d_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
    end else if (busy_q) begin
      if (cnt_q == Steps) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {q_mag(num_i), 32'd0};
      d_q    <= q_mag(den_i);
      r_q    <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
      neg_q  <= num_i[63] ^ den_i[63];
    end else if (busy_q && (cnt_q != Steps)) begin
      r_q    <= ge ? diff[63:0] : rn[63:0];
      over_q <= over_q | quo_q[63];
      quo_q  <= {quo_q[62:0], ge};
      dvd_q  <= {dvd_q[94:0], 1'b0};
    end
  end

  assign done_o = busy_q && (cnt_q == Steps);
  assign res_o  = q_from_mag(neg_q, over_q ? '1 : quo_q);

endmodule

>>> src/sor_linear_solver.sv
`timescale 1ns / 1ps
// Successive over-relaxation solver for A x = b, Q32.32 fixed point.
// Input channel (in_valid_i / in_stall_o): one beat per augmented-matrix
// element, one per cycle while idle; the beat with load_done set starts
// the solve and in_stall_o stays high until the last result beat is taken.
// Output channel (out_valid_o / out_stall_i): system_size beats, clamped to
// 1..MaxUnknowns, x[0] first, each with converged and zero-pivot flags and
// sweep count; a stalled beat holds in the output register.
// Configuration (cfg_valid_i / cfg_ready_o): always ready, write only idle.
// The multiplier is shared by the dot products, the residual squares and
// the relaxation scaling; the divider is used once per updated unknown.
// A run costs (sweeps+1) residual passes and sweeps relaxation sweeps,
// each sweep preceded by a pivot check of the diagonal elements.
// The matrix memory has no clearing pass.
// Reset returns the sequencer to idle and the configuration registers to their defaults.
module sor_linear_solver import sor_pkg::*; #(
  parameter int MaxUnknowns = MaxUnknownsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  sor_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output sor_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int Stride = MaxUnknowns + 1;
  localparam int MDepth = MaxUnknowns * Stride;
  localparam int AW     = $clog2(MDepth);
  localparam int IW     = $clog2(MaxUnknowns);
  localparam int CW     = $clog2(MaxUnknowns + 1);

  logic [6:0]  sys_q;
  logic [33:0] relax_q;
  logic [32:0] tol_q;
  logic [15:0] lim_q;

  sor_state_e       state_q, state_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d, n_q, n_d, i_nxt, j_nxt, n_clamp;
  logic             mode_q, mode_d, conv_q, conv_d, piv_q, piv_d;
  logic [15:0]      sweep_q, sweep_d;
  logic [MaxUnknowns-1:0] xval_q, xval_d;
  logic             outv_q, outv_d;
  logic signed [63:0] acc_q, acc_d, res_q, res_d;
  sor_out_t         outd_q, outd_d;

  logic               in_acc, out_acc, i_last;
  logic               m_we, x_we;
  logic [AW-1:0]      m_waddr, m_raddr;
  logic [IW-1:0]      x_raddr;
  logic signed [63:0] m_rd, x_rd, xv_j, xv_i, x_wdata;
  logic               mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_res, div_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q   <= SysSizeRst;
      relax_q <= RelaxRst;
      tol_q   <= TolSqRst;
      lim_q   <= IterLimRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SYSTEM_SIZE: sys_q   <= cfg_data_i[6:0];
        REG_RELAX:       relax_q <= cfg_data_i[33:0];
        REG_TOL_SQ:      tol_q   <= cfg_data_i[32:0];
        REG_ITER_LIMIT:  lim_q   <= cfg_data_i[15:0];
        default:         lim_q   <= lim_q;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = outv_q && !out_stall_i;
  assign i_nxt      = CW'(i_q + CW'(1));
  assign j_nxt      = CW'(j_q + CW'(1));
  assign i_last     = (i_nxt == n_q);

  always_comb begin
    priority if (sys_q == 7'd0) begin
      n_clamp = CW'(1);
    end else if (int'(sys_q) > MaxUnknowns) begin
      n_clamp = CW'(MaxUnknowns);
    end else begin
      n_clamp = CW'(sys_q);
    end
  end

  assign m_we    = in_acc && (int'(in_data_i.row_index) < MaxUnknowns)
                   && (int'(in_data_i.col_index) <= MaxUnknowns);
  assign m_waddr = AW'(int'(in_data_i.row_index) * Stride + int'(in_data_i.col_index));

  always_comb begin
    unique case (state_q)
      S_DOT_RD: m_raddr = AW'(int'(i_q) * Stride + int'(j_q));
      S_B_RD:   m_raddr = AW'(int'(i_q) * Stride + int'(n_q));
      default:  m_raddr = AW'(int'(i_q) * Stride + int'(i_q));
    endcase
  end

  assign x_raddr = (state_q == S_DOT_RD) ? j_q[IW-1:0] : i_q[IW-1:0];
  assign xv_j    = xval_q[j_q[IW-1:0]] ? x_rd : '0;
  assign xv_i    = xval_q[i_q[IW-1:0]] ? x_rd : '0;

  sor_ram #(.Width(64), .Depth(MDepth)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (in_data_i.element_value),
    .raddr_i (m_raddr),
    .rdata_o (m_rd)
  );

  sor_ram #(.Width(64), .Depth(MaxUnknowns)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (i_q[IW-1:0]),
    .wdata_i (x_wdata),
    .raddr_i (x_raddr),
    .rdata_o (x_rd)
  );

  sor_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  sor_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (m_rd),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    mode_d    = mode_q;
    conv_d    = conv_q;
    piv_d     = piv_q;
    sweep_d   = sweep_q;
    xval_d    = xval_q;
    outv_d    = outv_q;
    acc_d     = acc_q;
    res_d     = res_q;
    outd_d    = outd_q;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = acc_q;
    div_start = 1'b0;
    x_we      = 1'b0;
    x_wdata   = q_add(xv_i, div_res);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.load_done) begin
          n_d     = n_clamp;
          xval_d  = '0;
          sweep_d = '0;
          conv_d  = 1'b0;
          piv_d   = 1'b0;
          i_d     = '0;
          j_d     = '0;
          acc_d   = '0;
          res_d   = '0;
          mode_d  = 1'b0;
          state_d = S_DOT_RD;
        end
      end
      S_DOT_RD: state_d = S_DOT_MUL;
      S_DOT_MUL: begin
        mul_start = 1'b1;
        mul_a     = m_rd;
        mul_b     = xv_j;
        state_d   = S_DOT_WT;
      end
      S_DOT_WT: begin
        if (mul_done) begin
          acc_d   = q_add(acc_q, mul_res);
          j_d     = j_nxt;
          state_d = (j_nxt == n_q) ? S_B_RD : S_DOT_RD;
        end
      end
      S_B_RD: state_d = S_B_USE;
      S_B_USE: begin
        acc_d   = mode_q ? q_sub(m_rd, acc_q) : q_sub(acc_q, m_rd);
        state_d = S_B_MUL;
      end
      S_B_MUL: begin
        mul_start = 1'b1;
        mul_a     = mode_q ? $signed({30'd0, relax_q}) : acc_q;
        state_d   = mode_q ? S_WR_WT : S_SQ_WT;
      end
      S_SQ_WT: begin
        if (mul_done) begin
          res_d   = q_add(res_q, mul_res);
          i_d     = i_nxt;
          j_d     = '0;
          acc_d   = '0;
          state_d = i_last ? S_CMP : S_DOT_RD;
        end
      end
      S_CMP: begin
        i_d = '0;
        priority if (64'(res_q) < {31'd0, tol_q}) begin
          conv_d  = 1'b1;
          state_d = S_OUT_RD;
        end else if (sweep_q >= lim_q) begin
          state_d = S_OUT_RD;
        end else begin
          state_d = S_PIV_RD;
        end
      end
      S_PIV_RD: state_d = S_PIV_CHK;
      S_PIV_CHK: begin
        priority if (m_rd == '0) begin
          piv_d   = 1'b1;
          i_d     = '0;
          state_d = S_OUT_RD;
        end else if (i_last) begin
          i_d     = '0;
          j_d     = '0;
          acc_d   = '0;
          mode_d  = 1'b1;
          state_d = S_DOT_RD;
        end else begin
          i_d     = i_nxt;
          state_d = S_PIV_RD;
        end
      end
      S_WR_WT: begin
        if (mul_done) begin
          acc_d   = mul_res;
          state_d = S_PV_RD;
        end
      end
      S_PV_RD: state_d = S_DIV;
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (div_done) begin
          x_we                  = 1'b1;
          xval_d[i_q[IW-1:0]]   = 1'b1;
          i_d                   = i_nxt;
          j_d                   = '0;
          acc_d                 = '0;
          state_d               = S_DOT_RD;
          if (i_last) begin
            sweep_d = sweep_q + 16'd1;
            i_d     = '0;
            res_d   = '0;
            mode_d  = 1'b0;
          end
        end
      end
      S_OUT_RD: state_d = S_OUT_LD;
      S_OUT_LD: begin
        outv_d               = 1'b1;
        outd_d.unknown_index = 6'(i_q);
        outd_d.unknown_value = xv_i;
        outd_d.last_unknown  = i_last;
        outd_d.converged     = conv_q;
        outd_d.zero_pivot    = piv_q;
        outd_d.sweeps_used   = sweep_q;
        state_d              = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (out_acc) begin
          outv_d  = 1'b0;
          i_d     = i_nxt;
          state_d = i_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= CW'(1);
      mode_q  <= 1'b0;
      conv_q  <= 1'b0;
      piv_q   <= 1'b0;
      sweep_q <= '0;
      xval_q  <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      mode_q  <= mode_d;
      conv_q  <= conv_d;
      piv_q   <= piv_d;
      sweep_q <= sweep_d;
      xval_q  <= xval_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    res_q  <= res_d;
    outd_q <= outd_d;
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = outd_q;

  `SOR_ASSERT_IMP(a_no_load_while_out, out_valid_o, in_stall_o, "input taken during output")
  `SOR_ASSERT_IMP(a_flags_exclusive, out_valid_o,
    !(out_data_o.converged && out_data_o.zero_pivot), "converged with zero pivot")
  `SOR_ASSERT_IMP(a_last_index, out_valid_o && out_data_o.last_unknown,
    out_data_o.unknown_index == 6'(n_q - CW'(1)), "last beat at wrong index")

endmodule

>>> tb/sor_linear_solver_tb.sv
`timescale 1ns / 1ps
module sor_linear_solver_tb;
  import sor_pkg::*;

  localparam int CycleLimit = 6_000_000;
  localparam int SettleCycles = 200;
  localparam logic signed [63:0] QOne = 64'sh1_0000_0000;

  typedef enum int {
    MAT_DOMINANT,
    MAT_WILD,
    MAT_EXTREME,
    MAT_ZERO_PIVOT,
    MAT_ZERO_RHS
  } matrix_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  sor_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  sor_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_SYSTEM_SIZE;
  logic [63:0] cfg_data_i = '0;

  sor_linear_solver dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  sor_in_t  element_queue[$];
  sor_out_t expected_unknowns[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       quiet = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;

  logic [6:0]  size_reg = SysSizeRst;
  logic [33:0] relax_reg = RelaxRst;
  logic [32:0] tol_reg = TolSqRst;
  logic [15:0] limit_reg = IterLimRst;

  logic signed [63:0] coeff[MaxUnknownsDef][MaxUnknownsDef + 1];
  logic signed [63:0] x_est[MaxUnknownsDef];

  function automatic logic [63:0] abs_val(logic signed [63:0] v);
    return v[63] ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] signed_sat(bit neg, logic [63:0] m);
    if (!neg) return m[63] ? QMax : $signed(m);
    if (m[63]) return QMin;
    return $signed(64'd0 - m);
  endfunction

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? QMin : QMax;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_diff(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? QMin : QMax;
    return s;
  endfunction

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0] m;
    p = {64'd0, abs_val(a)} * {64'd0, abs_val(b)};
    m = (p[127:96] != 0) ? '1 : p[95:32];
    return signed_sat(a[63] != b[63], m);
  endfunction

  function automatic logic signed [63:0] fx_div(logic signed [63:0] num,
                                                logic signed [63:0] den);
    logic [127:0] q;
    logic [63:0] m;
    q = {32'd0, abs_val(num), 32'd0} / {64'd0, abs_val(den)};
    m = (q[127:64] != 0) ? '1 : q[63:0];
    return signed_sat(num[63] != den[63], m);
  endfunction

  function automatic logic signed [63:0] row_product(int row, int n);
    logic signed [63:0] acc;
    acc = 0;
    for (int j = 0; j < n; j++) acc = sat_sum(acc, fx_mul(coeff[row][j], x_est[j]));
    return acc;
  endfunction

  function automatic logic [63:0] residual_norm_sq(int n);
    logic signed [63:0] acc, d;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      d = sat_diff(row_product(i, n), coeff[i][n]);
      acc = sat_sum(acc, fx_mul(d, d));
    end
    return acc;
  endfunction

  function automatic void solve_system();
    int n;
    logic [15:0] sweeps;
    bit conv, pivot_bad;
    logic signed [63:0] r, w;
    sor_out_t res;
    n = (size_reg == 0) ? 1 : (size_reg > MaxUnknownsDef) ? MaxUnknownsDef : int'(size_reg);
    w = $signed({30'd0, relax_reg});
    for (int i = 0; i < MaxUnknownsDef; i++) x_est[i] = 0;
    sweeps = 0;
    conv = 0;
    pivot_bad = 0;
    while (1) begin
      if (residual_norm_sq(n) < {31'd0, tol_reg}) begin
        conv = 1;
        break;
      end
      if (sweeps >= limit_reg) break;
      for (int i = 0; i < n; i++) if (coeff[i][i] == 0) pivot_bad = 1;
      if (pivot_bad) break;
      for (int i = 0; i < n; i++) begin
        r = sat_diff(coeff[i][n], row_product(i, n));
        x_est[i] = sat_sum(x_est[i], fx_div(fx_mul(w, r), coeff[i][i]));
      end
      sweeps++;
    end
    for (int i = 0; i < n; i++) begin
      res.unknown_index = i[5:0];
      res.unknown_value = x_est[i];
      res.last_unknown  = (i == n - 1);
      res.converged     = conv;
      res.zero_pivot    = pivot_bad;
      res.sweeps_used   = sweeps;
      expected_unknowns.push_back(res);
    end
  endfunction

  function automatic void accept_element(sor_in_t e);
    if (e.col_index <= MaxUnknownsDef) coeff[e.row_index][e.col_index] = e.element_value;
    if (e.load_done) solve_system();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) accept_element(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (element_queue.size() > 0) begin
          in_data_i <= element_queue.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    sor_out_t exp_beat;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_unknowns.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data_o);
          error_count++;
        end else begin
          exp_beat = expected_unknowns.pop_front();
          if (out_data_o.unknown_index !== exp_beat.unknown_index) begin
            $display("%0t: unknown_index exp %0d got %0d", $time,
                     exp_beat.unknown_index, out_data_o.unknown_index);
            error_count++;
          end
          if (out_data_o.unknown_value !== exp_beat.unknown_value) begin
            $display("%0t: unknown_value exp %h got %h", $time,
                     exp_beat.unknown_value, out_data_o.unknown_value);
            error_count++;
          end
          if (out_data_o.last_unknown !== exp_beat.last_unknown) begin
            $display("%0t: last_unknown exp %b got %b", $time,
                     exp_beat.last_unknown, out_data_o.last_unknown);
            error_count++;
          end
          if (out_data_o.converged !== exp_beat.converged) begin
            $display("%0t: converged exp %b got %b", $time,
                     exp_beat.converged, out_data_o.converged);
            error_count++;
          end
          if (out_data_o.zero_pivot !== exp_beat.zero_pivot) begin
            $display("%0t: zero_pivot exp %b got %b", $time,
                     exp_beat.zero_pivot, out_data_o.zero_pivot);
            error_count++;
          end
          if (out_data_o.sweeps_used !== exp_beat.sweeps_used) begin
            $display("%0t: sweeps_used exp %0d got %0d", $time,
                     exp_beat.sweeps_used, out_data_o.sweeps_used);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic sor_in_t make_element(int row, int col, logic signed [63:0] v, bit done);
    sor_in_t e;
    e.row_index = row[5:0];
    e.col_index = col[6:0];
    e.element_value = v;
    e.load_done = done;
    return e;
  endfunction

  function automatic logic signed [63:0] rand_wide();
    return $signed({$urandom, $urandom});
  endfunction

  function automatic logic signed [63:0] rand_frac();
    logic signed [63:0] f;
    f = $signed({32'd0, $urandom});
    return $urandom_range(0, 1) ? -f : f;
  endfunction

  function automatic logic signed [63:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return QMax;
      1: return QMin;
      2: return 0;
      3: return QOne;
      default: return -QOne;
    endcase
  endfunction

  function automatic logic signed [63:0] make_value(matrix_kind_e kind, int row, int col, int n);
    bit diag, rhs;
    diag = (row == col);
    rhs = (col == n);
    case (kind)
      MAT_WILD: return ($urandom_range(0, 9) == 0) ? 64'sd0 : rand_wide();
      MAT_EXTREME: return pick_extreme();
      MAT_ZERO_PIVOT: begin
        if (diag && row == n - 1) return 0;
        if (diag) return 4 * QOne + $signed({32'd0, $urandom});
        if (rhs) return $signed({29'd0, 3'($urandom), $urandom}) + QOne;
        return rand_frac();
      end
      default: begin
        if (rhs) return (kind == MAT_ZERO_RHS) ? 64'sd0
                        : ($urandom_range(0, 1) ? 64'sd1 : -64'sd1) *
                          $signed({29'd0, 3'($urandom), $urandom});
        if (diag) return 4 * QOne + $signed({32'd0, $urandom});
        return ($signed({32'd0, $urandom}) >>> (n > 2 ? 2 : 1)) * (rand_frac() < 0 ? -1 : 1);
      end
    endcase
  endfunction

  function automatic int active_size();
    return (size_reg == 0) ? 1 : (size_reg > MaxUnknownsDef) ? MaxUnknownsDef : int'(size_reg);
  endfunction

  // shuffle the whole system, last element carries load_done
  function automatic int queue_system(matrix_kind_e kind);
    sor_in_t beats[$];
    sor_in_t tmp;
    int n, k;
    n = active_size();
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) beats.push_back(make_element(r, c, make_value(kind, r, c, n), 0));
    for (int i = beats.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = beats[i];
      beats[i] = beats[k];
      beats[k] = tmp;
    end
    beats[beats.size() - 1].load_done = 1'b1;
    foreach (beats[i]) element_queue.push_back(beats[i]);
    return beats.size();
  endfunction

  function automatic void queue_noise(bit done);
    element_queue.push_back(make_element($urandom_range(0, 63), $urandom_range(0, 127),
                                         rand_wide(), done));
  endfunction

  task automatic drain();
    while (element_queue.size() > 0 || in_valid_i || expected_unknowns.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SYSTEM_SIZE: size_reg = value[6:0];
      REG_RELAX:       relax_reg = value[33:0];
      REG_TOL_SQ:      tol_reg = value[32:0];
      default:         limit_reg = value[15:0];
    endcase
  endtask

  task automatic configure(logic [63:0] sz, logic [63:0] w, logic [63:0] tol,
                           logic [63:0] lim);
    drain();
    write_reg(REG_SYSTEM_SIZE, sz);
    write_reg(REG_RELAX, w);
    write_reg(REG_TOL_SQ, tol);
    write_reg(REG_ITER_LIMIT, lim);
  endtask

  task automatic random_phase(int target);
    int sent;
    bit loaded;
    sent = 0;
    loaded = 0;
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) queue_noise(0);
        if (loaded && $urandom_range(0, 2) == 0) queue_noise(1);
      end
      sent += queue_system($urandom_range(0, 3) == 0 ? MAT_EXTREME : MAT_WILD);
      loaded = 1;
      if ($urandom_range(0, 4) == 0) drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(2, 64'h1_0000_0000, 43, 65535);
    void'(queue_system(MAT_DOMINANT));
    void'(queue_system(MAT_ZERO_RHS));
    void'(queue_system(MAT_ZERO_PIVOT));
    void'(queue_system(MAT_DOMINANT));

    configure(0, 64'h2_0000_0000, 0, 0);
    void'(queue_system(MAT_EXTREME));
    element_queue.push_back(make_element(0, 0, QMax, 0));
    element_queue.push_back(make_element(0, 1, QMin, 1));

    configure(3, 64'h1_8000_0000, 64'h1_0000_0000, 3);
    void'(queue_system(MAT_EXTREME));
    random_phase(80);

    configure(5, 64'h1_0000_0000, 64'h1_0000_0000, 1);
    void'(queue_system(MAT_WILD));

    configure(4, {30'd0, 2'($urandom_range(0, 3)), $urandom},
              {31'd0, 1'($urandom_range(0, 1)), $urandom}, 64'($urandom_range(1, 5)));
    random_phase(70);

    configure(3, 0, {31'd0, 1'($urandom_range(0, 1)), $urandom}, 6);
    void'(queue_system(MAT_DOMINANT));

    configure(2, 64'h1_4000_0000, 43, 65535);
    quiet = 1'b1;
    repeat (3) void'(queue_system(MAT_DOMINANT));

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sor_linear_solver.f
+incdir+src
src/sor_pkg.sv
src/sor_ram.sv
src/sor_mul.sv
src/sor_div.sv
src/sor_linear_solver.sv
tb/sor_linear_solver_tb.sv
